[rtl/bpa_pkg.sv]
// ============================================================================
// Buddy page allocator package
// Shared widths, codes, descriptor layout and channel word types.
// ============================================================================
`default_nettype none

package bpa_pkg;

  localparam int NUM_PAGES  = 1024;
  localparam int PAGE_BITS  = 10;
  localparam int MAX_ORDER  = 6;
  localparam int BIN_COUNT  = MAX_ORDER + 1;
  localparam int BIN_BITS   = 3;
  localparam int ORDER_BITS = 4;
  localparam int OWNER_BITS = 3;
  localparam int CNT_BITS   = 11;
  localparam int MAX_SPAN   = 1 << MAX_ORDER;
  localparam int TAIL_BITS  = MAX_ORDER;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_BIG     = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic                  free_f;
    logic                  head_f;
    logic [ORDER_BITS-1:0] order;
    logic [OWNER_BITS-1:0] owner;
    logic                  prev_v;
    logic [PAGE_BITS-1:0]  prev;
    logic                  next_v;
    logic [PAGE_BITS-1:0]  next;
  } desc_t;

  typedef struct packed {
    logic                  opcode;
    logic [15:0]           size_pages;
    logic [2:0]            owner_tag;
    logic [9:0]            page_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [9:0]            block_page;
    logic [3:0]            block_order;
    logic [2:0]            freed_owner;
    logic [10:0]           pages_in_use;
  } out_word_t;

  typedef struct packed {
    logic                  en;
    logic [BIN_BITS-1:0]   order;
    logic                  valid;
    logic [PAGE_BITS-1:0]  page;
  } bin_wr_t;

endpackage

`default_nettype wire

[rtl/bpa_desc_ram.sv]
// ============================================================================
// Page descriptor memory
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bpa_desc_ram (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [bpa_pkg::PAGE_BITS-1:0] wr_addr,
  input  bpa_pkg::desc_t               wr_data,
  input  wire                          rd_en,
  input  wire  [bpa_pkg::PAGE_BITS-1:0] rd_addr,
  output bpa_pkg::desc_t               rd_data
);
  import bpa_pkg::*;

  desc_t mem [NUM_PAGES];
  desc_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/bpa_bins.sv]
// ============================================================================
// Free bin heads
// Head page and valid flag of each order's free list.
// ============================================================================
`default_nettype none

module bpa_bins (
  input  wire                           clk,
  input  wire                           rst_n,
  input  bpa_pkg::bin_wr_t              bin_wr,
  input  wire  [bpa_pkg::BIN_BITS-1:0]  rd_sel,
  output logic [bpa_pkg::BIN_COUNT-1:0] valid,
  output logic [bpa_pkg::PAGE_BITS-1:0] rd_head
);
  import bpa_pkg::*;

  logic [BIN_COUNT-1:0] valid_r;
  logic [PAGE_BITS-1:0] head_r [BIN_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (bin_wr.en) begin
      valid_r[bin_wr.order] <= bin_wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bin_wr.en) begin
      head_r[bin_wr.order] <= bin_wr.page;
    end
  end

  assign valid   = valid_r;
  assign rd_head = head_r[rd_sel];

endmodule

`default_nettype wire

[rtl/buddy_page_allocator.sv]
// ============================================================================
// Buddy page allocator
// Allocates and frees power-of-two page blocks kept in a descriptor memory.
// ============================================================================
// One word is handled at a time. After reset the descriptor memory is
// cleared in a pass over every page during which no word is accepted. An
// oversized or out-of-memory allocate and a free beyond the page limit are
// answered from idle, with the result registered as the word is accepted;
// a double free or a free of a tail or untouched page is answered from the
// page check once its descriptor is read. A successful allocate reads the
// block taken from its bin and relinks its successor, if any (a freshly
// reserved block skips both), writes a free buddy for each split level,
// and writes the head and tail descriptors of every page of the block (up
// to 64). A successful free checks the page, unlinks and clears the buddy at
// each merge level, makes the last buddy test and does the final push. The
// sequence is set by the single read and single write port of the descriptor
// memory, which the split, merge and list walk steps go through.
// ============================================================================
`default_nettype none

module buddy_page_allocator (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  bpa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output bpa_pkg::out_word_t out_data,
  input  wire                cfg_wr_en,
  input  wire  [10:0]        cfg_wr_data
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_UNL, S_A_FIX, S_SPLIT, S_TAIL, S_F_CHK, S_M_TEST,
    S_M_CHK, S_M_FIXP, S_M_NEXT, S_M_FIXN, S_M_CLR, S_PUSH, S_P_FIX
  } state_t;

  state_t               state_r;
  logic [PAGE_BITS-1:0] clr_r;
  logic [CNT_BITS-1:0]  usable_r;
  logic [CNT_BITS-1:0]  ro_r;
  logic [CNT_BITS-1:0]  used_r;
  logic [BIN_BITS-1:0]  ord_r;
  logic [BIN_BITS-1:0]  k_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [OWNER_BITS-1:0] fowner_r;
  logic [PAGE_BITS-1:0] blk_r;
  logic [PAGE_BITS-1:0] bud_r;
  logic [PAGE_BITS-1:0] fix_addr_r;
  logic [TAIL_BITS-1:0] cnt_r;
  desc_t                lnk_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  // Memory and bin controls.
  logic                 wr_en;
  logic [PAGE_BITS-1:0] wr_addr;
  desc_t                wr_data;
  logic                 rd_en;
  logic [PAGE_BITS-1:0] rd_addr;
  desc_t                rd_q;
  bin_wr_t              bin_wr;
  logic [BIN_BITS-1:0]  bin_sel;
  logic [BIN_COUNT-1:0] bin_valid;
  logic [PAGE_BITS-1:0] bin_head;

  // Decode of an incoming word.
  logic                 accept;
  logic [15:0]          n_w;
  logic                 big_w;
  logic [BIN_BITS-1:0]  ord_w;
  logic [BIN_COUNT-1:0] avail_w;
  logic [BIN_BITS-1:0]  kf_w;
  logic                 any_w;
  logic                 no_room_w;
  logic                 idx_bad_w;
  logic [2:0]           idle_st_w;

  // Working values of the sequencer.
  logic [BIN_BITS-1:0]  kd_w;
  logic [PAGE_BITS-1:0] split_bud_w;
  logic [PAGE_BITS-1:0] merge_bud_w;
  logic                 merge_stop_w;
  logic                 bud_match_w;
  logic [TAIL_BITS-1:0] tail_last_w;
  logic [BIN_BITS-1:0]  fk_w;
  logic [CNT_BITS-1:0]  fspan_w;
  logic [CNT_BITS-1:0]  aspan_w;

  bpa_desc_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  bpa_bins u_bins (
    .clk     (clk),
    .rst_n   (rst_n),
    .bin_wr  (bin_wr),
    .rd_sel  (bin_sel),
    .valid   (bin_valid),
    .rd_head (bin_head)
  );

  // A word is taken only when the sequencer is idle and the result slot is
  // empty or is being emptied in this cycle.
  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;

  // Request size rounded up to an order, and the lowest usable bin.
  always_comb begin
    n_w   = (in_data.size_pages == 16'd0) ? 16'd1 : in_data.size_pages;
    big_w = n_w > 16'(MAX_SPAN);
    ord_w = BIN_BITS'(MAX_ORDER);
    for (int j = MAX_ORDER; j >= 0; j--) begin
      if ((17'(1) << j) >= {1'b0, n_w}) begin
        ord_w = BIN_BITS'(j);
      end
    end
    for (int j = 0; j < BIN_COUNT; j++) begin
      avail_w[j] = bin_valid[j] && (BIN_BITS'(j) >= ord_w);
    end
    any_w = |avail_w;
    kf_w  = '0;
    for (int j = MAX_ORDER; j >= 0; j--) begin
      if (avail_w[j]) begin
        kf_w = BIN_BITS'(j);
      end
    end
    no_room_w = ({1'b0, ro_r} + 12'(MAX_SPAN)) > {1'b0, usable_r};
    idx_bad_w = {1'b0, in_data.page_index} >= usable_r;
    // Status of a word that is answered at once; OK for the others.
    if (in_data.opcode == OP_ALLOC) begin
      idle_st_w = big_w ? ST_BIG : ((!any_w && no_room_w) ? ST_OOM : ST_OK);
    end else begin
      idle_st_w = idx_bad_w ? ST_INVALID : ST_OK;
    end
  end

  always_comb begin
    kd_w         = k_r - BIN_BITS'(1);
    split_bud_w  = blk_r + (PAGE_BITS'(1) << kd_w);
    merge_bud_w  = blk_r ^ (PAGE_BITS'(1) << k_r);
    merge_stop_w = (k_r == BIN_BITS'(MAX_ORDER)) || ({1'b0, merge_bud_w} >= usable_r);
    bud_match_w  = rd_q.free_f && rd_q.head_f && (rd_q.order == {1'b0, k_r});
    tail_last_w  = TAIL_BITS'((7'd1 << ord_r) - 7'd1);
    fk_w         = (rd_q.order > ORDER_BITS'(MAX_ORDER)) ? BIN_BITS'(MAX_ORDER)
                                                         : rd_q.order[BIN_BITS-1:0];
    fspan_w      = CNT_BITS'(1) << fk_w;
    aspan_w      = CNT_BITS'(1) << ord_r;
  end

  // Memory and bin port drive per sequencer state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    bin_wr  = '0;
    bin_sel = (state_r == S_IDLE) ? kf_w : k_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_ALLOC) begin
            if (!big_w && any_w) begin
              rd_en   = 1'b1;
              rd_addr = bin_head;
            end
          end else if (!idx_bad_w) begin
            rd_en   = 1'b1;
            rd_addr = in_data.page_index;
          end
        end
      end
      S_A_UNL: begin
        // The taken block is the list head: its successor becomes the head.
        bin_wr = '{en: 1'b1, order: k_r, valid: rd_q.next_v, page: rd_q.next};
        if (rd_q.next_v) begin
          rd_en   = 1'b1;
          rd_addr = rd_q.next;
        end
      end
      S_A_FIX: begin
        wr_en          = 1'b1;
        wr_addr        = fix_addr_r;
        wr_data        = rd_q;
        wr_data.prev_v = 1'b0;
        wr_data.prev   = '0;
      end
      S_SPLIT: begin
        // Bins from the requested up to the taken order are empty, so a push is a single write.
        if (k_r > ord_r) begin
          wr_en          = 1'b1;
          wr_addr        = split_bud_w;
          wr_data.free_f = 1'b1;
          wr_data.head_f = 1'b1;
          wr_data.order  = {1'b0, kd_w};
          bin_wr = '{en: 1'b1, order: kd_w, valid: 1'b1, page: split_bud_w};
        end
      end
      S_TAIL: begin
        wr_en          = 1'b1;
        wr_addr        = blk_r + PAGE_BITS'(cnt_r);
        wr_data.head_f = (cnt_r == '0);
        wr_data.order  = {1'b0, ord_r};
        wr_data.owner  = owner_r;
      end
      S_M_TEST: begin
        if (!merge_stop_w) begin
          rd_en   = 1'b1;
          rd_addr = merge_bud_w;
        end
      end
      S_M_CHK: begin
        if (bud_match_w) begin
          if (rd_q.prev_v) begin
            rd_en   = 1'b1;
            rd_addr = rd_q.prev;
          end else begin
            bin_wr = '{en: 1'b1, order: k_r, valid: rd_q.next_v, page: rd_q.next};
          end
        end
      end
      S_M_FIXP: begin
        wr_en          = 1'b1;
        wr_addr        = fix_addr_r;
        wr_data        = rd_q;
        wr_data.next_v = lnk_r.next_v;
        wr_data.next   = lnk_r.next;
      end
      S_M_NEXT: begin
        if (lnk_r.next_v) begin
          rd_en   = 1'b1;
          rd_addr = lnk_r.next;
        end
      end
      S_M_FIXN: begin
        wr_en          = 1'b1;
        wr_addr        = fix_addr_r;
        wr_data        = rd_q;
        wr_data.prev_v = lnk_r.prev_v;
        wr_data.prev   = lnk_r.prev;
      end
      S_M_CLR: begin
        wr_en   = 1'b1;
        wr_addr = (bud_r < blk_r) ? blk_r : bud_r;
      end
      S_PUSH: begin
        wr_en          = 1'b1;
        wr_addr        = blk_r;
        wr_data.free_f = 1'b1;
        wr_data.head_f = 1'b1;
        wr_data.order  = {1'b0, k_r};
        wr_data.next_v = bin_valid[k_r];
        wr_data.next   = bin_head;
        bin_wr = '{en: 1'b1, order: k_r, valid: 1'b1, page: blk_r};
        if (bin_valid[k_r]) begin
          rd_en   = 1'b1;
          rd_addr = bin_head;
        end
      end
      S_P_FIX: begin
        wr_en          = 1'b1;
        wr_addr        = fix_addr_r;
        wr_data        = rd_q;
        wr_data.prev_v = 1'b1;
        wr_data.prev   = blk_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and registered result word. The result slot is empty in
  // every state but idle, so it is only emptied there.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      usable_r    <= CNT_BITS'(NUM_PAGES);
      ro_r        <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        usable_r <= (cfg_wr_data > CNT_BITS'(NUM_PAGES)) ? CNT_BITS'(NUM_PAGES)
                                                         : cfg_wr_data;
      end
      if (rd_en) begin
        fix_addr_r <= rd_addr;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + PAGE_BITS'(1);
          if (clr_r == PAGE_BITS'(NUM_PAGES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            owner_r  <= in_data.owner_tag;
            ord_r    <= ord_w;
            fowner_r <= '0;
            out_data_r <= '{status: idle_st_w, block_page: '0, block_order: '0,
                            freed_owner: '0, pages_in_use: used_r};
            if (in_data.opcode == OP_ALLOC) begin
              if (big_w) begin
                out_valid_r <= 1'b1;
              end else if (any_w) begin
                k_r         <= kf_w;
                blk_r       <= bin_head;
                out_valid_r <= 1'b0;
                state_r     <= S_A_UNL;
              end else if (no_room_w) begin
                out_valid_r <= 1'b1;
              end else begin
                // Fresh top-order block: pushing and popping it leaves no
                // trace in the lists, so the split starts at once.
                k_r         <= BIN_BITS'(MAX_ORDER);
                blk_r       <= ro_r[PAGE_BITS-1:0];
                ro_r        <= ro_r + CNT_BITS'(MAX_SPAN);
                out_valid_r <= 1'b0;
                state_r     <= S_SPLIT;
              end
            end else begin
              blk_r <= in_data.page_index;
              if (idx_bad_w) begin
                out_valid_r <= 1'b1;
              end else begin
                out_valid_r <= 1'b0;
                state_r     <= S_F_CHK;
              end
            end
          end else if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
        end
        S_A_UNL: begin
          state_r <= rd_q.next_v ? S_A_FIX : S_SPLIT;
        end
        S_A_FIX: begin
          state_r <= S_SPLIT;
        end
        S_SPLIT: begin
          if (k_r > ord_r) begin
            k_r <= kd_w;
          end else begin
            cnt_r   <= '0;
            state_r <= S_TAIL;
          end
        end
        S_TAIL: begin
          cnt_r <= cnt_r + TAIL_BITS'(1);
          if (cnt_r == tail_last_w) begin
            used_r      <= used_r + aspan_w;
            out_data_r  <= '{status: ST_OK, block_page: blk_r,
                             block_order: {1'b0, ord_r}, freed_owner: '0,
                             pages_in_use: used_r + aspan_w};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_F_CHK: begin
          if (rd_q.free_f) begin
            out_data_r.status <= ST_DOUBLE;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end else if (!rd_q.head_f) begin
            out_data_r.status <= ST_INVALID;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end else begin
            k_r      <= fk_w;
            fowner_r <= rd_q.owner;
            used_r   <= (used_r >= fspan_w) ? used_r - fspan_w : '0;
            state_r  <= S_M_TEST;
          end
        end
        S_M_TEST: begin
          bud_r   <= merge_bud_w;
          state_r <= merge_stop_w ? S_PUSH : S_M_CHK;
        end
        S_M_CHK: begin
          lnk_r <= rd_q;
          if (!bud_match_w) begin
            state_r <= S_PUSH;
          end else begin
            state_r <= rd_q.prev_v ? S_M_FIXP : S_M_NEXT;
          end
        end
        S_M_FIXP: begin
          state_r <= S_M_NEXT;
        end
        S_M_NEXT: begin
          state_r <= lnk_r.next_v ? S_M_FIXN : S_M_CLR;
        end
        S_M_FIXN: begin
          state_r <= S_M_CLR;
        end
        S_M_CLR: begin
          if (bud_r < blk_r) begin
            blk_r <= bud_r;
          end
          k_r     <= k_r + BIN_BITS'(1);
          state_r <= S_M_TEST;
        end
        S_PUSH: begin
          out_data_r <= '{status: ST_OK, block_page: blk_r, block_order: {1'b0, k_r},
                          freed_owner: fowner_r, pages_in_use: used_r};
          if (bin_valid[k_r]) begin
            state_r <= S_P_FIX;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_P_FIX: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("word accepted during descriptor clearing");

  a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_OK)) |->
    ((out_data_r.block_page & ((PAGE_BITS'(1) << out_data_r.block_order) -
      PAGE_BITS'(1))) == '0))
    else $error("result block not aligned to its order");

  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.block_order <= ORDER_BITS'(MAX_ORDER)))
    else $error("result order above top order");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != S_IDLE))
    else $error("descriptor write while idle");
`endif

endmodule

`default_nettype wire

[sim/buddy_page_allocator_tb.sv]
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free words into the allocator, predicts each answer
// with a behavioral model of the page descriptors and free bins, and checks
// every answer field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  always #5 clk = ~clk;

  buddy_page_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Shadow copy of the allocator state. Links are kept with valid bits so
  // that the LIFO order of each bin matches the block exactly.
  logic            pg_free [NUM_PAGES];
  logic            pg_head [NUM_PAGES];
  int unsigned     pg_order[NUM_PAGES];
  int unsigned     pg_owner[NUM_PAGES];
  logic            pg_pv   [NUM_PAGES];
  int unsigned     pg_prev [NUM_PAGES];
  logic            pg_nv   [NUM_PAGES];
  int unsigned     pg_next [NUM_PAGES];
  logic            bin_v   [BIN_COUNT];
  int unsigned     bin_top [BIN_COUNT];
  int unsigned     reserve_ptr;
  int unsigned     shadow_used;
  int unsigned     page_limit;

  out_word_t answer_q[$];
  int unsigned mismatches = 0;
  int unsigned answers_seen = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit timed_out = 0;

  function automatic void model_reset();
    for (int i = 0; i < NUM_PAGES; i++) begin
      pg_free[i] = 0; pg_head[i] = 0; pg_order[i] = 0; pg_owner[i] = 0;
      pg_pv[i] = 0; pg_prev[i] = 0; pg_nv[i] = 0; pg_next[i] = 0;
    end
    for (int k = 0; k < BIN_COUNT; k++) begin
      bin_v[k] = 0;
      bin_top[k] = 0;
    end
    reserve_ptr = 0;
    shadow_used = 0;
    page_limit = NUM_PAGES;
  endfunction

  function automatic void shadow_push(int unsigned k, int unsigned node);
    pg_pv[node] = 0;
    pg_prev[node] = 0;
    pg_nv[node] = bin_v[k];
    pg_next[node] = bin_top[k];
    if (bin_v[k]) begin
      pg_pv[bin_top[k]] = 1;
      pg_prev[bin_top[k]] = node;
    end
    bin_top[k] = node;
    bin_v[k] = 1;
  endfunction

  function automatic void bin_unlink(int unsigned k, int unsigned node);
    if (pg_pv[node]) begin
      pg_nv[pg_prev[node]] = pg_nv[node];
      pg_next[pg_prev[node]] = pg_next[node];
    end else begin
      bin_v[k] = pg_nv[node];
      bin_top[k] = pg_next[node];
    end
    if (pg_nv[node]) begin
      pg_pv[pg_next[node]] = pg_pv[node];
      pg_prev[pg_next[node]] = pg_prev[node];
    end
    pg_pv[node] = 0; pg_prev[node] = 0; pg_nv[node] = 0; pg_next[node] = 0;
  endfunction

  // Applies one word to the shadow state and returns the answer it causes.
  function automatic out_word_t allocator_answer(in_word_t w);
    out_word_t r;
    int unsigned n, ord, k, blk, bud, idx;
    r = '0;
    r.status = ST_OK;
    if (w.opcode == OP_ALLOC) begin
      n = (w.size_pages == 0) ? 1 : w.size_pages;
      if (n > MAX_SPAN) begin
        r.status = ST_BIG;
      end else begin
        ord = 0;
        while ((1 << ord) < n) ord++;
        k = ord;
        while (k <= MAX_ORDER && !bin_v[k]) k++;
        if (k > MAX_ORDER && reserve_ptr + MAX_SPAN <= page_limit) begin
          pg_free[reserve_ptr] = 1; pg_head[reserve_ptr] = 1;
          pg_order[reserve_ptr] = MAX_ORDER; pg_owner[reserve_ptr] = 0;
          shadow_push(MAX_ORDER, reserve_ptr);
          reserve_ptr += MAX_SPAN;
          k = MAX_ORDER;
        end
        if (k > MAX_ORDER) begin
          r.status = ST_OOM;
        end else begin
          blk = bin_top[k];
          bin_unlink(k, blk);
          while (k > ord) begin
            k--;
            bud = blk + (1 << k);
            pg_free[bud] = 1; pg_head[bud] = 1; pg_order[bud] = k; pg_owner[bud] = 0;
            shadow_push(k, bud);
          end
          pg_free[blk] = 0; pg_head[blk] = 1; pg_order[blk] = ord;
          pg_owner[blk] = w.owner_tag;
          for (int i = 1; i < (1 << ord); i++) begin
            pg_owner[blk + i] = w.owner_tag; pg_free[blk + i] = 0;
            pg_head[blk + i] = 0; pg_order[blk + i] = ord;
          end
          shadow_used += (1 << ord);
          r.block_page = 10'(blk);
          r.block_order = 4'(ord);
        end
      end
    end else begin
      idx = w.page_index;
      if (idx >= page_limit) begin
        r.status = ST_INVALID;
      end else if (pg_free[idx]) begin
        r.status = ST_DOUBLE;
      end else if (!pg_head[idx]) begin
        r.status = ST_INVALID;
      end else begin
        k = (pg_order[idx] > MAX_ORDER) ? MAX_ORDER : pg_order[idx];
        shadow_used = (shadow_used >= (1 << k)) ? shadow_used - (1 << k) : 0;
        r.freed_owner = 3'(pg_owner[idx]);
        pg_free[idx] = 1; pg_head[idx] = 1; pg_owner[idx] = 0; pg_order[idx] = k;
        // Merge upward while the buddy is a free head of the same order.
        while (k < MAX_ORDER) begin
          bud = idx ^ (1 << k);
          if (bud >= page_limit) break;
          if (!(pg_free[bud] && pg_head[bud] && pg_order[bud] == k)) break;
          bin_unlink(k, bud);
          if (bud < idx) begin
            pg_free[idx] = 0; pg_head[idx] = 0; pg_order[idx] = 0;
            idx = bud;
          end else begin
            pg_free[bud] = 0; pg_head[bud] = 0; pg_order[bud] = 0;
          end
          k++;
          pg_order[idx] = k; pg_head[idx] = 1; pg_free[idx] = 1;
        end
        shadow_push(k, idx);
        r.block_page = 10'(idx);
        r.block_order = 4'(k);
      end
    end
    r.pages_in_use = 11'(shadow_used);
    return r;
  endfunction

  // Result side: random stall, and a field-by-field comparison of each answer taken.
  always @(negedge clk) begin
    out_stall <= (receiver_stall_pct > 0) &&
                 ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer word %p", out_data);
      end else begin
        out_word_t exp_w;
        exp_w = answer_q.pop_front();
        if (out_data.status !== exp_w.status ||
            out_data.block_page !== exp_w.block_page ||
            out_data.block_order !== exp_w.block_order ||
            out_data.freed_owner !== exp_w.freed_owner ||
            out_data.pages_in_use !== exp_w.pages_in_use) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: expected %p, got %p", exp_w, out_data);
        end
      end
    end
  end

  // Watchdog: counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("watchdog: no progress, %0d answers pending", answer_q.size());
      $display("buddy_page_allocator_tb: done, errors");
      $finish;
    end
  end

  // Sends one word and queues its expected answer once it is taken. The
  // input side is driven with blocking writes at the falling edge so that a
  // word that follows at once can raise valid again in the same step.
  task automatic send_word(in_word_t w);
    while ((sender_idle_pct > 0) && ($urandom_range(99) < sender_idle_pct))
      @(negedge clk);
    in_valid = 1'b1;
    in_data = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    answer_q.push_back(allocator_answer(w));
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Lets the block drain, then writes the page limit while it is idle.
  task automatic set_page_limit(int unsigned v);
    while (answer_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[10:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    page_limit = (v > NUM_PAGES) ? NUM_PAGES : v;
  endtask

  function automatic in_word_t make_word(logic op, int unsigned sz, int unsigned own,
                                         int unsigned pg);
    in_word_t w;
    w.opcode = op;
    w.size_pages = sz[15:0];
    w.owner_tag = own[2:0];
    w.page_index = pg[9:0];
    return w;
  endfunction

  // Directed table. Answers typed in where they are obvious; a status of
  // 7 marks a row left to the predictor alone.
  typedef struct {
    in_word_t  w;
    out_word_t known;
  } vector_row_t;

  localparam logic [2:0] ST_PREDICT = 3'd7;

  vector_row_t vectors[$];

  function automatic out_word_t answer_of(logic [2:0] st, int unsigned pg, int unsigned ord,
                                          int unsigned own, int unsigned used);
    out_word_t r;
    r.status = st; r.block_page = pg[9:0]; r.block_order = ord[3:0];
    r.freed_owner = own[2:0]; r.pages_in_use = used[10:0];
    return r;
  endfunction

  task automatic build_vectors();
    out_word_t p;
    p = answer_of(ST_PREDICT, 0, 0, 0, 0);
    // Freeing anything right after reset: untouched pages are invalid.
    vectors.push_back('{make_word(OP_FREE, 0, 0, 0), answer_of(ST_INVALID, 0, 0, 0, 0)});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 1023),
                        answer_of(ST_INVALID, 0, 0, 0, 0)});
    // Oversized requests, including the largest size field.
    vectors.push_back('{make_word(OP_ALLOC, 65535, 7, 0), answer_of(ST_BIG, 0, 0, 0, 0)});
    vectors.push_back('{make_word(OP_ALLOC, 65, 0, 0), answer_of(ST_BIG, 0, 0, 0, 0)});
    // Zero pages counts as one; first reservation starts at page zero.
    vectors.push_back('{make_word(OP_ALLOC, 0, 5, 1023), answer_of(ST_OK, 0, 0, 0, 1)});
    vectors.push_back('{make_word(OP_ALLOC, 64, 7, 0), answer_of(ST_OK, 64, 6, 0, 65)});
    vectors.push_back('{make_word(OP_ALLOC, 3, 2, 0), p});
    vectors.push_back('{make_word(OP_ALLOC, 33, 1, 0), p});
    vectors.push_back('{make_word(OP_ALLOC, 16, 6, 0), p});
    // Tail page of the order-6 block, then a double free of a split buddy.
    vectors.push_back('{make_word(OP_FREE, 0, 0, 65),
                        answer_of(ST_INVALID, 0, 0, 0, 149)});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 1), p});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 64), p});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 64), p});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 0), p});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 4), p});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 128), p});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 160), p});
    vectors.push_back('{make_word(OP_ALLOC, 2, 3, 0), p});
    vectors.push_back('{make_word(OP_ALLOC, 8, 4, 0), p});
    vectors.push_back('{make_word(OP_FREE, 0, 0, 1000), p});
  endtask

  // Random traffic: mostly allocates and frees of live blocks, some noise.
  task automatic random_traffic(int unsigned count);
    int unsigned live[$];
    int unsigned sel, pg, sz;
    in_word_t w;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        sz = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(64);
        w = make_word(OP_ALLOC, sz, $urandom_range(7), $urandom_range(1023));
      end else if (sel < 88 && live.size() != 0) begin
        pg = $urandom_range(live.size() - 1);
        w = make_word(OP_FREE, $urandom(), $urandom_range(7), live[pg]);
        live.delete(pg);
      end else begin
        w = make_word(OP_FREE, $urandom(), $urandom_range(7), $urandom_range(1023));
      end
      send_word(w);
      if (w.opcode == OP_ALLOC && answer_q[$].status == ST_OK)
        live.push_back(answer_q[$].block_page);
    end
    // Drop the live list by freeing everything so later phases start clean.
    foreach (live[j]) send_word(make_word(OP_FREE, 0, 0, live[j]));
  endtask

  initial begin
    model_reset();
    build_vectors();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows, no idling; reset limit of 1024 pages.
    foreach (vectors[i]) begin
      send_word(vectors[i].w);
      if (vectors[i].known.status != ST_PREDICT && answer_q[$] != vectors[i].known) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: predictor %p, typed %p", i, answer_q[$],
                   vectors[i].known);
      end
    end

    // Small limits force out-of-memory and out-of-range frees; values above
    // the page count must behave as the full count.
    set_page_limit(0);
    random_traffic(40);
    set_page_limit(100);
    random_traffic(60);
    set_page_limit(2047);

    sender_idle_pct = 53;
    random_traffic(230);
    // Hold the sender until every outstanding answer has returned.
    while (answer_q.size() != 0) @(negedge clk);
    sender_idle_pct = 0;
    receiver_stall_pct = 53;
    random_traffic(230);
    set_page_limit(1024);
    sender_idle_pct = 20;
    receiver_stall_pct = 20;
    random_traffic(230);
    set_page_limit(600);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    random_traffic(230);

    while (answer_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d words and %0d answers over page limits 0 to 2047,",
             words_sent, answers_seen);
    $display("with sender gaps and receiver stalls mixed in; %0d mismatches", mismatches);
    if (mismatches == 0 && answer_q.size() == 0)
      $display("buddy_page_allocator_tb: done, clean");
    else
      $display("buddy_page_allocator_tb: done, errors");
    $finish;
  end
endmodule

[sim.f]
rtl/bpa_pkg.sv
rtl/bpa_desc_ram.sv
rtl/bpa_bins.sv
rtl/buddy_page_allocator.sv
sim/buddy_page_allocator_tb.sv
